[src/gauss_forward_interpolator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the interpolator RTL.
// Each macro expects signals clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef GAUSS_FORWARD_INTERPOLATOR_DEFINES_SVH
`define GAUSS_FORWARD_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define GFI_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define GFI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/gfi_pkg.sv]
// ----------------------------------------------------------------------------
// gfi_pkg
// Widths, operation codes and status codes of the Gauss forward interpolator.
// ----------------------------------------------------------------------------
package gfi_pkg;

  localparam int DEF_MAX_POINTS = 16;
  localparam int MODE_W = 2;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_NBR = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FEW    = 2'd2;

endpackage

[src/gfi_item_if.sv]
// ----------------------------------------------------------------------------
// gfi_item_if
// Input channel: one transaction carries a mode and an (x, y) pair.
// ----------------------------------------------------------------------------
interface gfi_item_if;
  import gfi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] x_value;
  logic signed [DATA_W-1:0] y_value;

  modport source (output valid, output mode, output x_value, output y_value, input ready);
  modport sink   (input valid, input mode, input x_value, input y_value, output ready);
endinterface

[src/gfi_result_if.sv]
// ----------------------------------------------------------------------------
// gfi_result_if
// Output channel: one transaction carries the interpolated value and a status.
// ----------------------------------------------------------------------------
interface gfi_result_if;
  import gfi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] interpolated;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output interpolated, output status, input ready);
  modport sink   (input valid, input interpolated, input status, output ready);
endinterface

[src/gauss_forward_interpolator.sv]
// Load and clear transactions emit no result.
// An answered query runs a search reading one stored abscissa per cycle, a
// 19-step one-bit-per-cycle divider for p (skipped when p saturates), five
// sample reads, and eleven products on one shared 28x21 multiplier with a
// byte-serial /3. A full output register adds a stall. One item is in work
// at a time. Reset empties the store and drops any pending result.
// ----------------------------------------------------------------------------
// gauss_forward_interpolator
// Fourth-order Gauss forward interpolation over equally spaced Q16.16 samples
// held in two synchronous memories.
// ----------------------------------------------------------------------------
`include "gauss_forward_interpolator_defines.svh"

module gauss_forward_interpolator #(
  parameter int MAX_POINTS = gfi_pkg::DEF_MAX_POINTS
) (
  input  logic         clk,
  input  logic         rst,
  gfi_item_if.sink     item,
  gfi_result_if.source result
);
  import gfi_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
  localparam logic signed [19:0] P_LIM = 20'sd262144;
  localparam logic signed [20:0] Q_ONE = 21'sd65536;

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH, S_CHK, S_DIV, S_YRD,
    S_C2M, S_C2C, S_C3M, S_C3C, S_C4M, S_C4C,
    S_THI, S_TLO, S_TSUM, S_TABS, S_TDIV, S_TACC, S_DONE
  } state_t;

  state_t state;

  // Sample memories and their registered read ports.
  logic signed [DATA_W-1:0] x_mem [MAX_POINTS];
  logic signed [DATA_W-1:0] y_mem [MAX_POINTS];
  logic signed [DATA_W-1:0] x_rd, y_rd;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;

  // Control and datapath registers.
  logic [CW-1:0]            count, n, j, i_idx;
  logic [2:0]               ycnt, dcnt;
  logic [4:0]               dstep;
  logic [1:0]               tsel, drem;
  logic signed [DATA_W-1:0] xq, x0, x1, x_prev;
  logic [51:0]              rem, dvs;
  logic [18:0]              quo;
  logic                     p_neg, tneg;
  logic signed [19:0]       p;
  logic signed [35:0]       d1, d2, d3, d4;
  logic signed [27:0]       c2, c3, c4;
  logic signed [48:0]       mprod, ph;
  logic signed [63:0]       prod;
  logic [47:0]              tsh;
  logic signed [49:0]       sum;
  logic signed [DATA_W-1:0] res_val, out_value;
  logic [STAT_W-1:0]        res_stat, out_status;
  logic                     out_valid;

  // Combinational helpers.
  logic signed [32:0] h, dx;
  logic [32:0]        dx_mag, h_mag;
  logic [51:0]        num_mag;
  logic               p_big;
  logic [CW:0]        i_plus2, n_ext;
  logic               div_ge;
  logic [18:0]        quo_next, quo_sat;
  logic signed [35:0] ys;
  logic signed [27:0] ma, coef_sel;
  logic signed [20:0] mb;
  logic signed [35:0] dsel;
  logic [63:0]        prod_mag;
  logic [4:0]         tshamt;
  logic [9:0]         dv;
  logic [19:0]        dv_mul;
  logic [8:0]         dq;
  logic signed [49:0] sum_next;
  logic signed [DATA_W-1:0] sum_sat;

  function automatic logic signed [32:0] trq(input logic signed [48:0] v);
    logic signed [48:0] b;
    b = v + (v[48] ? 49'sd65535 : 49'sd0);
    return 33'(b >>> 16);
  endfunction

  assign item.ready          = (state == S_IDLE);
  assign result.valid        = out_valid;
  assign result.interpolated = out_value;
  assign result.status       = out_status;

  assign wr_en = item.valid && item.ready && (item.mode == MODE_LOAD) && (count < CNT_MAX);

  // Memory read address follows the sequencer.
  always_comb begin
    case (state)
      S_SRCH:  rd_addr = AW'(j + CW'(1));
      S_YRD:   rd_addr = AW'(i_idx - CW'(2) + CW'(ycnt));
      default: rd_addr = '0;
    endcase
  end

  // Sample memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[count[AW-1:0]] <= item.x_value;
      y_mem[count[AW-1:0]] <= item.y_value;
    end
    x_rd <= x_mem[rd_addr];
    y_rd <= y_mem[rd_addr];
  end

  // Spacing, offset and the divider set-up.
  assign h       = 33'(x1) - 33'(x0);
  assign dx      = 33'(xq) - 33'(x_prev);
  assign dx_mag  = dx[32] ? 33'(-dx) : 33'(dx);
  assign h_mag   = h[32] ? 33'(-h) : 33'(h);
  assign num_mag = {3'b0, dx_mag, 16'b0};
  assign p_big   = num_mag >= {h_mag, 19'b0};
  assign i_plus2 = {1'b0, i_idx} + (CW + 1)'(2);
  assign n_ext   = {1'b0, n};

  // Restoring divider step.
  assign div_ge   = rem >= dvs;
  assign quo_next = {quo[17:0], div_ge};
  assign quo_sat  = (quo_next > 19'd262144) ? 19'd262144 : quo_next;

  assign ys = 36'(y_rd);

  // Operand selection for the term being built.
  always_comb begin
    case (tsel)
      2'd0:    begin coef_sel = 28'(p); dsel = d1; end
      2'd1:    begin coef_sel = c2;     dsel = d2; end
      2'd2:    begin coef_sel = c3;     dsel = d3; end
      default: begin coef_sel = c4;     dsel = d4; end
    endcase
  end

  // Shared multiplier operands.
  always_comb begin
    case (state)
      S_C2M:   begin ma = 28'(p); mb = 21'(p) - Q_ONE; end
      S_C3M:   begin ma = c2;     mb = 21'(p) + Q_ONE; end
      S_C4M:   begin ma = c3;     mb = 21'(p) - (Q_ONE <<< 1); end
      S_THI:   begin ma = coef_sel; mb = 21'($signed(dsel[35:16])); end
      S_TLO:   begin ma = coef_sel; mb = {5'b0, dsel[15:0]}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Term magnitude and its power-of-two part of the divisor.
  assign prod_mag = prod[63] ? 64'(-prod) : 64'(prod);
  always_comb begin
    case (tsel)
      2'd0:    tshamt = 5'd16;
      2'd1:    tshamt = 5'd17;
      2'd2:    tshamt = 5'd17;
      default: tshamt = 5'd19;
    endcase
  end

  // Byte-serial division by three: reciprocal multiply on a 10-bit digit.
  assign dv     = {drem, tsh[47:40]};
  assign dv_mul = 20'(dv) * 20'd683;
  assign dq     = dv_mul[19:11];

  // Accumulation and output saturation.
  assign sum_next = sum + (tneg ? -50'($signed({2'b0, tsh})) : 50'($signed({2'b0, tsh})));
  always_comb begin
    if (sum_next > 50'sd2147483647) begin
      sum_sat = 32'sh7FFFFFFF;
    end else if (sum_next < -50'sd2147483648) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = 32'(sum_next);
    end
  end

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    mprod <= ma * mb;
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // A result handed over while a new one is loaded stays valid.
      if (out_valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            case (item.mode)
              MODE_LOAD: begin
                if (count < CNT_MAX) begin
                  count <= count + CW'(1);
                end
              end
              MODE_CLEAR: begin
                count <= '0;
              end
              MODE_QUERY: begin
                n  <= count;
                xq <= item.x_value;
                j  <= '0;
                if (count < CW'(2)) begin
                  res_val  <= '0;
                  res_stat <= STAT_FEW;
                  state    <= S_DONE;
                end else begin
                  state <= S_SRCH;
                end
              end
              default: begin
              end
            endcase
          end
        end

        // One stored abscissa is checked per cycle.
        S_SRCH: begin
          if (j == '0) begin
            x0     <= x_rd;
            x_prev <= x_rd;
            j      <= j + CW'(1);
          end else begin
            if (j == CW'(1)) begin
              x1 <= x_rd;
            end
            if (x_rd >= xq) begin
              i_idx <= j - CW'(1);
              state <= S_CHK;
            end else if (j == n - CW'(1)) begin
              res_val  <= '0;
              res_stat <= STAT_NO_NBR;
              state    <= S_DONE;
            end else begin
              x_prev <= x_rd;
              j      <= j + CW'(1);
            end
          end
        end

        // Neighbor and spacing checks, then divider start or saturated p.
        S_CHK: begin
          if (i_idx < CW'(2) || i_plus2 >= n_ext || h == '0) begin
            res_val  <= '0;
            res_stat <= STAT_NO_NBR;
            state    <= S_DONE;
          end else if (p_big) begin
            p     <= (dx[32] ^ h[32]) ? -P_LIM : P_LIM;
            ycnt  <= '0;
            state <= S_YRD;
          end else begin
            rem   <= num_mag;
            dvs   <= {1'b0, h_mag, 18'b0};
            quo   <= '0;
            dstep <= '0;
            p_neg <= dx[32] ^ h[32];
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_ge) begin
            rem <= rem - dvs;
          end
          quo   <= quo_next;
          dvs   <= dvs >> 1;
          dstep <= dstep + 5'd1;
          if (dstep == 5'd18) begin
            p     <= p_neg ? -$signed({1'b0, quo_sat}) : $signed({1'b0, quo_sat});
            ycnt  <= '0;
            state <= S_YRD;
          end
        end

        // Samples i-2 .. i+2 arrive one per cycle and build the differences.
        S_YRD: begin
          ycnt <= ycnt + 3'd1;
          case (ycnt)
            3'd1: begin
              d1 <= '0;
              d2 <= '0;
              d3 <= '0;
              d4 <= ys;
            end
            3'd2: begin
              d2 <= d2 + ys;
              d3 <= d3 - ys;
              d4 <= d4 - (ys <<< 2);
            end
            3'd3: begin
              d1  <= d1 - ys;
              d2  <= d2 - (ys <<< 1);
              d3  <= d3 + (ys <<< 1) + ys;
              d4  <= d4 + (ys <<< 2) + (ys <<< 1);
              sum <= 50'(y_rd);
            end
            3'd4: begin
              d1 <= d1 + ys;
              d2 <= d2 + ys;
              d3 <= d3 - (ys <<< 1) - ys;
              d4 <= d4 - (ys <<< 2);
            end
            3'd5: begin
              d3    <= d3 + ys;
              d4    <= d4 + ys;
              state <= S_C2M;
            end
            default: begin
            end
          endcase
        end

        // Coefficient products, each truncated toward zero to Q16.16.
        S_C2M: state <= S_C2C;
        S_C2C: begin
          c2    <= 28'(trq(mprod));
          state <= S_C3M;
        end
        S_C3M: state <= S_C3C;
        S_C3C: begin
          c3    <= 28'(trq(mprod));
          state <= S_C4M;
        end
        S_C4M: state <= S_C4C;
        S_C4C: begin
          c4    <= 28'(trq(mprod));
          tsel  <= 2'd0;
          state <= S_THI;
        end

        // Each term: two partial products, magnitude, scaling, accumulate.
        S_THI: state <= S_TLO;
        S_TLO: begin
          ph    <= mprod;
          state <= S_TSUM;
        end
        S_TSUM: begin
          prod  <= (64'(ph) <<< 16) + 64'(mprod);
          state <= S_TABS;
        end
        S_TABS: begin
          tsh  <= 48'(prod_mag >> tshamt);
          tneg <= prod[63];
          drem <= '0;
          dcnt <= '0;
          if (tsel >= 2'd2) begin
            state <= S_TDIV;
          end else begin
            state <= S_TACC;
          end
        end
        S_TDIV: begin
          tsh  <= {tsh[39:0], dq[7:0]};
          drem <= 2'(dv - 10'(dq) - 10'(dq << 1));
          dcnt <= dcnt + 3'd1;
          if (dcnt == 3'd5) begin
            state <= S_TACC;
          end
        end
        S_TACC: begin
          sum <= sum_next;
          if (tsel == 2'd3) begin
            res_val  <= sum_sat;
            res_stat <= STAT_OK;
            state    <= S_DONE;
          end else begin
            tsel  <= tsel + 2'd1;
            state <= S_THI;
          end
        end

        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_value  <= res_val;
            out_status <= res_stat;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `GFI_ASSERT(a_count_range, 1'b1, count <= CNT_MAX, "sample count above capacity")
  `GFI_ASSERT(a_srch_idx, state == S_SRCH, j < n, "search index past stored samples")
  `GFI_ASSERT(a_nbr_ok, state == S_YRD, i_idx >= CW'(2) && i_plus2 < n_ext, "neighbors missing")
  `GFI_ASSERT(a_err_zero, out_valid && out_status != STAT_OK, out_value == '0, "error value")
  `GFI_ASSERT_NEXT(a_done_load, state == S_DONE && !out_valid, out_valid, "result not loaded")

endmodule

[sim/gauss_forward_interpolator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gauss_forward_interpolator_test
// Drives load, query and clear transactions into the interpolator, predicts
// each query result with a local fixed-point model of the Gauss forward
// formula and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module gauss_forward_interpolator_test;
  import gfi_pkg::*;

  localparam int NPTS      = DEF_MAX_POINTS;
  localparam int QONE      = 65536;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [STAT_W-1:0]        status;
  } interp_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gfi_item_if   item ();
  gfi_result_if result ();

  gauss_forward_interpolator #(.MAX_POINTS(NPTS)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source)
  );

  always #5 clk = ~clk;

  // Local copy of the sample store.
  logic signed [DATA_W-1:0] x_copy [NPTS];
  logic signed [DATA_W-1:0] y_copy [NPTS];
  int unsigned              stored_pts = 0;

  interp_result_t expected_values [$];
  int  error_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  quiet_cycles = 0;

  // Forward difference of the given order starting at sample j.
  function automatic longint fwd_diff(int unsigned j, int order);
    longint y0, y1, y2, y3, y4;
    y0 = y_copy[j];
    y1 = y_copy[j+1];
    if (order == 1) return y1 - y0;
    y2 = y_copy[j+2];
    if (order == 2) return y2 - 2*y1 + y0;
    y3 = y_copy[j+3];
    if (order == 3) return y3 - 3*y2 + 3*y1 - y0;
    y4 = y_copy[j+4];
    return y4 - 4*y3 + 6*y2 - 4*y1 + y0;
  endfunction

  // Applies one accepted transaction to the local store and queues the
  // expected result of a query.
  function automatic void apply_item(logic [MODE_W-1:0] md, logic signed [DATA_W-1:0] xv,
                                     logic signed [DATA_W-1:0] yv);
    interp_result_t r;
    longint xq, h, p, c2, c3, c4, sum;
    int unsigned j, i;
    bit found;
    xq = xv;
    if (md == MODE_LOAD) begin
      if (stored_pts < NPTS) begin
        x_copy[stored_pts] = xv;
        y_copy[stored_pts] = yv;
        stored_pts++;
      end
      return;
    end
    if (md == MODE_CLEAR) begin
      stored_pts = 0;
      return;
    end
    if (md != MODE_QUERY) return;
    r.value = '0;
    if (stored_pts < 2) begin
      r.status = STAT_FEW;
      expected_values.push_back(r);
      return;
    end
    found = 1'b0;
    j = stored_pts;
    for (int unsigned k = 1; k < stored_pts; k++) begin
      if (!found && longint'(x_copy[k]) >= xq) begin
        found = 1'b1;
        j = k;
      end
    end
    i = j - 1;
    h = longint'(x_copy[1]) - longint'(x_copy[0]);
    if (i < 2 || i + 2 >= stored_pts || h == 0) begin
      r.status = STAT_NO_NBR;
      expected_values.push_back(r);
      return;
    end
    p = ((xq - longint'(x_copy[i])) * QONE) / h;
    if (p > 4*QONE) p = 4*QONE;
    if (p < -4*QONE) p = -4*QONE;
    c2 = (p * (p - QONE)) / QONE;
    c3 = (c2 * (p + QONE)) / QONE;
    c4 = (c3 * (p - 2*QONE)) / QONE;
    sum = y_copy[i];
    sum += (p * fwd_diff(i, 1)) / QONE;
    sum += (c2 * fwd_diff(i-1, 2)) / (2*QONE);
    sum += (c3 * fwd_diff(i-1, 3)) / (6*QONE);
    sum += (c4 * fwd_diff(i-2, 4)) / (24*QONE);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    r.value  = sum[DATA_W-1:0];
    r.status = STAT_OK;
    expected_values.push_back(r);
  endfunction

  // Sends one transaction, with random idle cycles ahead of it.
  task automatic send_item(logic [MODE_W-1:0] md, logic signed [DATA_W-1:0] xv,
                           logic signed [DATA_W-1:0] yv);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      item.valid <= 1'b0;
    end
    @(negedge clk);
    item.valid   <= 1'b1;
    item.mode    <= md;
    item.x_value <= xv;
    item.y_value <= yv;
    forever begin
      @(posedge clk);
      if (item.ready) break;
    end
    apply_item(md, xv, yv);
  endtask

  // Loads an equally spaced sample set after clearing the store.
  task automatic load_set(int n, longint x0, longint h, bit wide_y);
    longint yv;
    send_item(MODE_CLEAR, $urandom, $urandom);
    for (int k = 0; k < n; k++) begin
      if (wide_y) yv = $signed($urandom);
      else yv = longint'(k*k) * 3000 - 40000 + $urandom_range(4095);
      send_item(MODE_LOAD, 32'(x0 + k*h), 32'(yv));
    end
  endtask

  // Receiver stalls at random.
  always @(negedge clk) begin
    result.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    interp_result_t e;
    if (!rst && result.valid && result.ready) begin
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d", $time,
                 result.interpolated, result.status);
        error_count++;
      end else begin
        e = expected_values.pop_front();
        if (result.interpolated !== e.value) begin
          $display("%0t: interpolated expected %0d actual %0d", $time, e.value,
                   result.interpolated);
          error_count++;
        end
        if (result.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, result.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[gauss_forward_interpolator] ERROR");
        $finish;
      end
    end
  end

  // Error statuses, spare mode and field extremes.
  task automatic test_directed();
    send_item(MODE_QUERY, 32'sh7fffffff, 32'sh7fffffff);
    send_item(MODE_LOAD, 32'sh80000000, 32'sh7fffffff);
    send_item(MODE_QUERY, 32'sh80000000, 32'sh0);
    send_item(MODE_SPARE, 32'sh7fffffff, 32'sh80000000);
    send_item(MODE_CLEAR, 32'sh0, 32'sh0);
    load_set(7, 0, QONE, 1'b1);
    send_item(MODE_QUERY, 32'sh0002_8000, 32'sh0);
    send_item(MODE_QUERY, 32'sh0003_0000, 32'sh0);
    send_item(MODE_QUERY, 32'sh0003_c000, 32'sh0);
    send_item(MODE_QUERY, 32'sh80000000, 32'sh0);
    send_item(MODE_QUERY, 32'sh7fffffff, 32'sh0);
    // Zero spacing between the first two samples.
    load_set(6, 32'sh1000, 0, 1'b0);
    send_item(MODE_QUERY, 32'sh1000, 32'shffffffff);
  endtask

  // Mostly well-formed sample sets with queries in and around them, plus noise.
  task automatic test_random(int n_items, int idle_pct, int stall_pct);
    int sent;
    int n, nq, pick;
    longint x0, h, off;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        n = $urandom_range(99) < 10 ? $urandom_range(17, 19) :
            ($urandom_range(99) < 6 ? $urandom_range(0, 4) : $urandom_range(5, 16));
        x0 = $urandom_range(99) < 20 ? longint'($signed($urandom)) / 4
                                     : longint'($urandom_range(200000)) - 100000;
        case ($urandom_range(9))
          0: h = -longint'($urandom_range(1, 3*QONE));
          1: h = $urandom_range(1, 50);
          2: h = longint'($urandom_range(1, 1 << 26));
          default: h = $urandom_range(QONE/4, 4*QONE);
        endcase
        load_set(n, x0, h, $urandom_range(3) == 0);
        nq = $urandom_range(2, 8);
        for (int q = 0; q < nq; q++) begin
          off = (longint'($urandom_range(0, 20*QONE)) - 2*QONE) * h / QONE;
          send_item(MODE_QUERY, 32'(x0 + off), $urandom);
        end
        sent += n + nq + 1;
      end else begin
        send_item(2'($urandom_range(3)), $urandom, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    item.valid   = 1'b0;
    item.mode    = MODE_LOAD;
    item.x_value = '0;
    item.y_value = '0;
    result.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(240, 0, 0);
    test_random(240, 70, 0);
    test_random(240, 0, 70);
    test_random(240, 34, 34);
    @(negedge clk);
    item.valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("[gauss_forward_interpolator] OK");
    end else begin
      $display("[gauss_forward_interpolator] ERROR");
    end
    $finish;
  end
endmodule
